// ----- hw/rtl/ifps_pkg.sv -----
// ============================================================================
// ifps_pkg: shared types and constants of the IMU frame parser and scaler
// Holds the frame kind codes, register indexes, reset values and the
// structures that pass configuration and parsed frames between modules.
// ============================================================================
package ifps_pkg;

   // Field widths.
   localparam int BYTE_WIDTH      = 8;
   localparam int RAW_WIDTH       = 16;
   localparam int SCALE_WIDTH     = 28;
   localparam int AXIS_WIDTH      = 32;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = SCALE_WIDTH;

   // Frame kinds as they appear on the result channel.
   typedef enum logic [1:0] {
      KIND_ACCEL = 2'd0,
      KIND_RATE  = 2'd1,
      KIND_ANGLE = 2'd2
   } kind_type;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HEADER_VALUE = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ACCEL_CODE   = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RATE_CODE    = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ANGLE_CODE   = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ACCEL_SCALE  = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RATE_SCALE   = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ANGLE_SCALE  = 3'd6;

   // Register reset values.
   localparam logic [BYTE_WIDTH-1:0]  HEADER_VALUE_RESET = 8'd85;
   localparam logic [BYTE_WIDTH-1:0]  ACCEL_CODE_RESET   = 8'd81;
   localparam logic [BYTE_WIDTH-1:0]  RATE_CODE_RESET    = 8'd82;
   localparam logic [BYTE_WIDTH-1:0]  ANGLE_CODE_RESET   = 8'd83;
   localparam logic [SCALE_WIDTH-1:0] ACCEL_SCALE_RESET  = 28'd10276045;
   localparam logic [SCALE_WIDTH-1:0] RATE_SCALE_RESET   = 28'd131072000;
   localparam logic [SCALE_WIDTH-1:0] ANGLE_SCALE_RESET  = 28'd11796480;

   // Configuration register set.
   typedef struct packed {
      logic [BYTE_WIDTH-1:0]  header_value;
      logic [BYTE_WIDTH-1:0]  accel_code;
      logic [BYTE_WIDTH-1:0]  rate_code;
      logic [BYTE_WIDTH-1:0]  angle_code;
      logic [SCALE_WIDTH-1:0] accel_scale;
      logic [SCALE_WIDTH-1:0] rate_scale;
      logic [SCALE_WIDTH-1:0] angle_scale;
   } cfg_type;

   // A frame that passed its checksum, waiting to be scaled.
   typedef struct packed {
      kind_type              kind;
      logic [RAW_WIDTH-1:0]  raw_x;
      logic [RAW_WIDTH-1:0]  raw_y;
      logic [RAW_WIDTH-1:0]  raw_z;
   } frame_type;

endpackage

// ----- hw/rtl/ifps_parser.sv -----
// ============================================================================
// ifps_parser: byte-level frame parser
// Hunts for the header byte, checks the type code, gathers the three
// little-endian axes and keeps the running checksum. A frame whose checksum
// matches is held as a valid frame until the scaler takes it.
// ============================================================================
module ifps_parser (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [ifps_pkg::BYTE_WIDTH-1:0] rx_byte,
   input  ifps_pkg::cfg_type             cfg,
   output logic                          frame_valid,
   input  logic                          frame_ready,
   output ifps_pkg::frame_type           frame
);
   import ifps_pkg::*;

   // Position within the eleven-byte frame.
   typedef enum logic [3:0] {
      POS_HEADER  = 4'd0,
      POS_TYPE    = 4'd1,
      POS_X_LO    = 4'd2,
      POS_X_HI    = 4'd3,
      POS_Y_LO    = 4'd4,
      POS_Y_HI    = 4'd5,
      POS_Z_LO    = 4'd6,
      POS_Z_HI    = 4'd7,
      POS_TEMP_LO = 4'd8,
      POS_TEMP_HI = 4'd9,
      POS_CHECK   = 4'd10
   } pos_type;

   pos_type               pos_ff, pos_in;
   logic [BYTE_WIDTH-1:0] sum_ff, sum_in;
   kind_type              kind_ff, kind_in;
   logic [RAW_WIDTH-1:0]  raw_x_ff, raw_x_in;
   logic [RAW_WIDTH-1:0]  raw_y_ff, raw_y_in;
   logic [RAW_WIDTH-1:0]  raw_z_ff, raw_z_in;
   logic                  frame_valid_ff, frame_valid_in;
   logic                  accept;
   logic [BYTE_WIDTH-1:0] sum_next;

   // The raw registers double as the frame payload, so no byte is taken
   // while a finished frame still waits for the scaler.
   assign in_ready = !frame_valid_ff || frame_ready;
   assign accept   = in_valid && in_ready;
   assign sum_next = sum_ff + rx_byte;

   // Next-state logic of the parser.
   always_comb begin
      pos_in         = pos_ff;
      sum_in         = sum_ff;
      kind_in        = kind_ff;
      raw_x_in       = raw_x_ff;
      raw_y_in       = raw_y_ff;
      raw_z_in       = raw_z_ff;
      frame_valid_in = frame_valid_ff && !frame_ready;
      if (accept) begin
         unique case (pos_ff)
            POS_HEADER: begin
               if (rx_byte == cfg.header_value) begin
                  sum_in = rx_byte;
                  pos_in = POS_TYPE;
               end
            end
            POS_TYPE: begin
               sum_in = sum_next;
               pos_in = POS_X_LO;
               priority if (rx_byte == cfg.accel_code) begin
                  kind_in = KIND_ACCEL;
               end else if (rx_byte == cfg.rate_code) begin
                  kind_in = KIND_RATE;
               end else if (rx_byte == cfg.angle_code) begin
                  kind_in = KIND_ANGLE;
               end else begin
                  // Unknown type code: back to header hunting.
                  sum_in = sum_ff;
                  pos_in = POS_HEADER;
               end
            end
            POS_X_LO: begin
               raw_x_in = {8'h00, rx_byte};
               sum_in   = sum_next;
               pos_in   = POS_X_HI;
            end
            POS_X_HI: begin
               raw_x_in = {rx_byte, raw_x_ff[7:0]};
               sum_in   = sum_next;
               pos_in   = POS_Y_LO;
            end
            POS_Y_LO: begin
               raw_y_in = {8'h00, rx_byte};
               sum_in   = sum_next;
               pos_in   = POS_Y_HI;
            end
            POS_Y_HI: begin
               raw_y_in = {rx_byte, raw_y_ff[7:0]};
               sum_in   = sum_next;
               pos_in   = POS_Z_LO;
            end
            POS_Z_LO: begin
               raw_z_in = {8'h00, rx_byte};
               sum_in   = sum_next;
               pos_in   = POS_Z_HI;
            end
            POS_Z_HI: begin
               raw_z_in = {rx_byte, raw_z_ff[7:0]};
               sum_in   = sum_next;
               pos_in   = POS_TEMP_LO;
            end
            // Temperature bytes only count towards the checksum.
            POS_TEMP_LO: begin
               sum_in = sum_next;
               pos_in = POS_TEMP_HI;
            end
            POS_TEMP_HI: begin
               sum_in = sum_next;
               pos_in = POS_CHECK;
            end
            POS_CHECK: begin
               pos_in = POS_HEADER;
               if (rx_byte == sum_ff) begin
                  frame_valid_in = 1'b1;
               end
            end
            default: begin
               pos_in = POS_HEADER;
            end
         endcase
      end
   end

   // State and frame registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff         <= POS_HEADER;
         sum_ff         <= '0;
         kind_ff        <= KIND_ACCEL;
         raw_x_ff       <= '0;
         raw_y_ff       <= '0;
         raw_z_ff       <= '0;
         frame_valid_ff <= 1'b0;
      end else begin
         pos_ff         <= pos_in;
         sum_ff         <= sum_in;
         kind_ff        <= kind_in;
         raw_x_ff       <= raw_x_in;
         raw_y_ff       <= raw_y_in;
         raw_z_ff       <= raw_z_in;
         frame_valid_ff <= frame_valid_in;
      end
   end

   assign frame_valid = frame_valid_ff;
   assign frame.kind  = kind_ff;
   assign frame.raw_x = raw_x_ff;
   assign frame.raw_y = raw_y_ff;
   assign frame.raw_z = raw_z_ff;

endmodule

// ----- hw/rtl/ifps_scaler.sv -----
// ============================================================================
// ifps_scaler: fixed-point axis scaler and result register
// Multiplies each signed raw axis by the full scale of the frame kind and
// shifts right arithmetically by 15, giving signed Q16.16 results.
// ============================================================================
module ifps_scaler (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           frame_valid,
   output logic                           frame_ready,
   input  ifps_pkg::frame_type            frame,
   input  ifps_pkg::cfg_type              cfg,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [1:0]                     rsp_frame_kind,
   output logic signed [ifps_pkg::AXIS_WIDTH-1:0] rsp_axis_x,
   output logic signed [ifps_pkg::AXIS_WIDTH-1:0] rsp_axis_y,
   output logic signed [ifps_pkg::AXIS_WIDTH-1:0] rsp_axis_z
);
   import ifps_pkg::*;

   localparam int PROD_WIDTH = RAW_WIDTH + SCALE_WIDTH + 1;
   localparam int SHIFT      = 15;
   localparam int KEEP_WIDTH = PROD_WIDTH - SHIFT;

   logic [SCALE_WIDTH-1:0]        scale;
   logic signed [PROD_WIDTH-1:0]  scale_ext;
   logic signed [PROD_WIDTH-1:0]  prod_x, prod_y, prod_z;
   logic                          load;
   logic                          rsp_valid_ff, rsp_valid_in;
   kind_type                      kind_ff;
   logic signed [AXIS_WIDTH-1:0]  axis_x_ff, axis_y_ff, axis_z_ff;

   // Full scale of the frame kind.
   always_comb begin
      unique case (frame.kind)
         KIND_ACCEL: scale = cfg.accel_scale;
         KIND_RATE:  scale = cfg.rate_scale;
         default:    scale = cfg.angle_scale;
      endcase
   end

   // Three signed multipliers, 16 by 29 bits.
   assign scale_ext = $signed({{(PROD_WIDTH-SCALE_WIDTH){1'b0}}, scale});
   assign prod_x = $signed({{(PROD_WIDTH-RAW_WIDTH){frame.raw_x[RAW_WIDTH-1]}}, frame.raw_x})
                   * scale_ext;
   assign prod_y = $signed({{(PROD_WIDTH-RAW_WIDTH){frame.raw_y[RAW_WIDTH-1]}}, frame.raw_y})
                   * scale_ext;
   assign prod_z = $signed({{(PROD_WIDTH-RAW_WIDTH){frame.raw_z[RAW_WIDTH-1]}}, frame.raw_z})
                   * scale_ext;

   // The result register takes a frame whenever it is empty or being emptied.
   assign frame_ready  = !rsp_valid_ff || rsp_ready;
   assign load         = frame_valid && frame_ready;
   assign rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload; the shifted product always fits in 32 bits.
   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff   <= frame.kind;
         axis_x_ff <= $signed({{(AXIS_WIDTH-KEEP_WIDTH){prod_x[PROD_WIDTH-1]}},
                              prod_x[PROD_WIDTH-1:SHIFT]});
         axis_y_ff <= $signed({{(AXIS_WIDTH-KEEP_WIDTH){prod_y[PROD_WIDTH-1]}},
                              prod_y[PROD_WIDTH-1:SHIFT]});
         axis_z_ff <= $signed({{(AXIS_WIDTH-KEEP_WIDTH){prod_z[PROD_WIDTH-1]}},
                              prod_z[PROD_WIDTH-1:SHIFT]});
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_frame_kind = kind_ff;
   assign rsp_axis_x     = axis_x_ff;
   assign rsp_axis_y     = axis_y_ff;
   assign rsp_axis_z     = axis_z_ff;

endmodule

// ----- hw/rtl/imu_frame_parser_scaler_core.sv -----
// ============================================================================
// imu_frame_parser_scaler_core: IMU serial frame parser and scaler
// Path: a frame with a good checksum is held in the parser's frame register,
// then in the result register, which raises rsp_valid, once that is free.
// Throughput: one byte per cycle; the parser's frame register and the result
// register each hold one frame, so bytes stall only while both are full and
// the result is not being taken.
// Reset: synchronous, active high; the parser returns to header hunting and
// all registers but the result payload take their default values.
// ============================================================================
module imu_frame_parser_scaler_core (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [ifps_pkg::BYTE_WIDTH-1:0]         req_rx_byte,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [1:0]                              rsp_frame_kind,
   output logic signed [ifps_pkg::AXIS_WIDTH-1:0]  rsp_axis_x,
   output logic signed [ifps_pkg::AXIS_WIDTH-1:0]  rsp_axis_y,
   output logic signed [ifps_pkg::AXIS_WIDTH-1:0]  rsp_axis_z,
   input  logic                                    csr_write_en,
   input  logic [ifps_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [ifps_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata
);
   import ifps_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   frame_type frame;
   logic      frame_valid;
   logic      frame_ready;

   // Configuration register writes; unknown indexes are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_HEADER_VALUE: cfg_in.header_value = csr_wdata[BYTE_WIDTH-1:0];
            CSR_ACCEL_CODE:   cfg_in.accel_code   = csr_wdata[BYTE_WIDTH-1:0];
            CSR_RATE_CODE:    cfg_in.rate_code    = csr_wdata[BYTE_WIDTH-1:0];
            CSR_ANGLE_CODE:   cfg_in.angle_code   = csr_wdata[BYTE_WIDTH-1:0];
            CSR_ACCEL_SCALE:  cfg_in.accel_scale  = csr_wdata[SCALE_WIDTH-1:0];
            CSR_RATE_SCALE:   cfg_in.rate_scale   = csr_wdata[SCALE_WIDTH-1:0];
            CSR_ANGLE_SCALE:  cfg_in.angle_scale  = csr_wdata[SCALE_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_value <= HEADER_VALUE_RESET;
         cfg_ff.accel_code   <= ACCEL_CODE_RESET;
         cfg_ff.rate_code    <= RATE_CODE_RESET;
         cfg_ff.angle_code   <= ANGLE_CODE_RESET;
         cfg_ff.accel_scale  <= ACCEL_SCALE_RESET;
         cfg_ff.rate_scale   <= RATE_SCALE_RESET;
         cfg_ff.angle_scale  <= ANGLE_SCALE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Byte parser with checksum.
   ifps_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_valid),
      .in_ready    (req_ready),
      .rx_byte     (req_rx_byte),
      .cfg         (cfg_ff),
      .frame_valid (frame_valid),
      .frame_ready (frame_ready),
      .frame       (frame)
   );

   // Axis scaling and result register.
   ifps_scaler u_scaler (
      .clock          (clock),
      .reset          (reset),
      .frame_valid    (frame_valid),
      .frame_ready    (frame_ready),
      .frame          (frame),
      .cfg            (cfg_ff),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_frame_kind (rsp_frame_kind),
      .rsp_axis_x     (rsp_axis_x),
      .rsp_axis_y     (rsp_axis_y),
      .rsp_axis_z     (rsp_axis_z)
   );

endmodule
